[hw/rtl/ppmh_pkg.sv]
// -----------------------------------------------------------------------------
// ppmh_pkg
// Shared types and constants of the pattern pdf match and histogram core:
// command codes, sequencer states and the layout of the per-pair memory word.
// -----------------------------------------------------------------------------
package ppmh_pkg;

   // default geometry
   localparam int LAYERS_DEF        = 18;
   localparam int REF_LAYERS_DEF    = 8;
   localparam int PDF_ADDR_BITS_DEF = 7;

   // fixed field widths
   localparam int PHI_W      = 14;
   localparam int PHI_BINS_W = 13;
   localparam int DIST_W     = 16;
   localparam int WVAL_W     = 17;
   localparam int PDF_W      = 16;
   localparam int SUM_W      = 32;
   localparam int CNT_W      = 16;
   // width used to form layer * REF_LAYERS + ref_layer before trimming
   localparam int PAIR_CALC_W = 10;

   localparam logic [PHI_BINS_W-1:0] PHI_BINS_RESET = 13'd5760;

   // command codes
   typedef enum logic [2:0] {
      CMD_EVAL    = 3'd0,
      CMD_ACCUM   = 3'd1,
      CMD_WR_PDF  = 3'd2,
      CMD_WR_MEAN = 3'd3,
      CMD_RD_STAT = 3'd4
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HIT,
      ST_LAST,
      ST_WRAP,
      ST_UPD,
      ST_OUT
   } state_type;

   // one word of the per-pair memory
   typedef struct packed {
      logic signed [PHI_W-1:0] mean;
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } pair_word_type;

   // magnitude of a signed distance
   function automatic logic [DIST_W-1:0] dist_mag(input logic signed [DIST_W-1:0] v);
      logic signed [DIST_W-1:0] n;
      n = -v;
      return v[DIST_W-1] ? DIST_W'(n) : DIST_W'(v);
   endfunction

endpackage

[hw/rtl/ppmh_ram.sv]
// -----------------------------------------------------------------------------
// ppmh_ram
// Generic single-write, single-read synchronous RAM. Read data is registered
// and holds its value until the next read.
// -----------------------------------------------------------------------------
module ppmh_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pattern_pdf_match_and_histogram_core.sv]
// -----------------------------------------------------------------------------
// pattern_pdf_match_and_histogram_core
// Per layer pair hit matching against a pdf table and histogram accumulation.
// -----------------------------------------------------------------------------
// One item is worked at a time; the tables live in two block RAMs, the pdf
// table (LAYERS*REF_LAYERS*2^PDF_ADDR_BITS words) and a per-pair word holding
// mean offset, distance sum and count; the best distance and hit count of a
// list are kept in registers. An ordinary hit is a pair word read, then a
// best-distance update. The last hit of an evaluate list adds a pdf read and
// the output transfer, the last hit of an accumulate list a pdf read, wrap and
// read-modify-write of both RAMs when it updates the histogram; a pdf or mean
// write is done in the hit step, a statistics read ends with the output
// transfer. The sequence follows from the registered read of the RAMs and the
// read-modify-write of the pdf bin. After reset a clearing pass zeroes both
// RAMs, one pdf word per cycle, over all pdf words (18432 with the defaults);
// no item is taken during it, phi_bins writes are.
// -----------------------------------------------------------------------------
module pattern_pdf_match_and_histogram_core #(
   parameter int LAYERS        = ppmh_pkg::LAYERS_DEF,
   parameter int REF_LAYERS    = ppmh_pkg::REF_LAYERS_DEF,
   parameter int PDF_ADDR_BITS = ppmh_pkg::PDF_ADDR_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [ppmh_pkg::PHI_BINS_W-1:0]        csr_wr_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [2:0]                             req_command,
   input  logic [4:0]                             req_layer,
   input  logic [2:0]                             req_ref_layer,
   input  logic signed [ppmh_pkg::PHI_W-1:0]      req_ref_phi,
   input  logic signed [ppmh_pkg::PHI_W-1:0]      req_hit_phi,
   input  logic                                   req_last_hit,
   input  logic [6:0]                             req_pdf_bin,
   input  logic signed [ppmh_pkg::WVAL_W-1:0]     req_write_value,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ppmh_pkg::PDF_W-1:0]             rsp_pdf_value,
   output logic                                   rsp_has_value,
   output logic signed [ppmh_pkg::SUM_W-1:0]      rsp_dist_sum,
   output logic [ppmh_pkg::CNT_W-1:0]             rsp_dist_count
);

   import ppmh_pkg::*;

   localparam int PAIRS     = LAYERS * REF_LAYERS;
   localparam int PDF_SIZE  = 1 << PDF_ADDR_BITS;
   localparam int PDF_DEPTH = PAIRS * PDF_SIZE;
   localparam int PAIR_AW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int PDF_AW    = (PDF_DEPTH > 1) ? $clog2(PDF_DEPTH) : 1;
   localparam int PAIR_DW   = $bits(pair_word_type);
   localparam int IDX_W     = DIST_W + 1;

   localparam logic [5:0]               LAYERS_LIM   = 6'(LAYERS);
   localparam logic [4:0]               REF_LIM      = 5'(REF_LAYERS);
   localparam logic [PAIR_CALC_W-1:0]   REF_MUL      = PAIR_CALC_W'(REF_LAYERS);
   localparam logic [PDF_AW-1:0]        PDF_LAST     = PDF_AW'(PDF_DEPTH - 1);
   localparam logic [PDF_AW-1:0]        PAIRS_LIM    = PDF_AW'(PAIRS);
   localparam logic signed [DIST_W-1:0] BEST_INIT    = DIST_W'(PDF_SIZE);
   localparam logic signed [IDX_W-1:0]  HALF_S       = IDX_W'(PDF_SIZE / 2);
   localparam logic signed [IDX_W-1:0]  PDF_SIZE_S   = IDX_W'(PDF_SIZE);
   localparam logic signed [SUM_W-1:0]  SUM_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN      = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [CNT_W-1:0]         CNT_MAX      = '1;
   localparam logic [PDF_W-1:0]         PDF_MAX      = '1;

   // control registers
   state_type                  state_ff, state_in;
   logic [PDF_AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [PHI_BINS_W-1:0]      phi_bins_ff, phi_bins_in;
   logic signed [DIST_W-1:0]   best_ff, best_in;
   logic [1:0]                 valid_hits_ff, valid_hits_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // captured item
   cmd_type                    cmd_ff, cmd_in;
   logic [PAIR_AW-1:0]         pair_ff, pair_in;
   logic                       ok_ff, ok_in;
   logic signed [PHI_W-1:0]    ref_ff, ref_in;
   logic signed [PHI_W-1:0]    hit_ff, hit_in;
   logic                       last_ff, last_in;
   logic [PDF_ADDR_BITS-1:0]   bin_ff, bin_in;
   logic signed [WVAL_W-1:0]   wval_ff, wval_in;

   // working registers
   logic                       sel_ok_ff, sel_ok_in;
   logic [PDF_AW-1:0]          lut_addr_ff, lut_addr_in;
   logic signed [DIST_W-1:0]   wrap_ff, wrap_in;

   // response payload
   logic [PDF_W-1:0]           rsp_pdf_ff, rsp_pdf_in;
   logic                       rsp_has_ff, rsp_has_in;
   logic signed [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic [CNT_W-1:0]           rsp_cnt_ff, rsp_cnt_in;

   // memory ports
   logic                       pdf_wr_en, pdf_rd_en;
   logic [PDF_AW-1:0]          pdf_wr_addr, pdf_rd_addr;
   logic [PDF_W-1:0]           pdf_wr_data, pdf_rd_data;
   logic                       pair_wr_en, pair_rd_en;
   logic [PAIR_AW-1:0]         pair_wr_addr, pair_rd_addr;
   pair_word_type              pair_wr_data, pair_rd_data;
   logic [PAIR_DW-1:0]         pair_rd_raw;

   // request decode
   logic                       req_xfer;
   logic                       req_ok;
   logic [PAIR_CALC_W-1:0]     req_pair_wide;
   logic [PAIR_AW-1:0]         req_pair;
   logic [PDF_ADDR_BITS-1:0]   req_bin;

   // hit datapath
   logic signed [PHI_W-1:0]    mean_s;
   logic signed [DIST_W-1:0]   dist_s;
   logic                       hit_in_range;
   logic signed [IDX_W-1:0]    idx_s;
   logic                       idx_ok;
   logic signed [DIST_W-1:0]   phi_s, hb_s, wrap_a, wrap_b;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   logic                       out_free;

   // pdf table and per-pair memories
   ppmh_ram #(
      .WIDTH (PDF_W),
      .DEPTH (PDF_DEPTH),
      .ADDR_W(PDF_AW)
   ) u_pdf_ram (
      .clock  (clock),
      .wr_en  (pdf_wr_en),
      .wr_addr(pdf_wr_addr),
      .wr_data(pdf_wr_data),
      .rd_en  (pdf_rd_en),
      .rd_addr(pdf_rd_addr),
      .rd_data(pdf_rd_data)
   );

   ppmh_ram #(
      .WIDTH (PAIR_DW),
      .DEPTH (PAIRS),
      .ADDR_W(PAIR_AW)
   ) u_pair_ram (
      .clock  (clock),
      .wr_en  (pair_wr_en),
      .wr_addr(pair_wr_addr),
      .wr_data(pair_wr_data),
      .rd_en  (pair_rd_en),
      .rd_addr(pair_rd_addr),
      .rd_data(pair_rd_raw)
   );

   assign pair_rd_data = pair_rd_raw;

   // request pair and bin
   assign req_xfer      = req_valid && !req_stall;
   assign req_ok        = ({1'b0, req_layer} < LAYERS_LIM) && ({2'b00, req_ref_layer} < REF_LIM);
   assign req_pair_wide = PAIR_CALC_W'(req_layer) * REF_MUL + PAIR_CALC_W'(req_ref_layer);
   assign req_pair      = req_ok ? req_pair_wide[PAIR_AW-1:0] : '0;
   assign req_bin       = PDF_ADDR_BITS'(req_pdf_bin);
   assign req_stall     = (state_ff != ST_IDLE);

   // distance of this hit, mean only for evaluate
   assign mean_s = (ok_ff && cmd_ff == CMD_EVAL) ? pair_rd_data.mean : '0;
   assign dist_s = DIST_W'(hit_ff) - DIST_W'(mean_s) - DIST_W'(ref_ff);
   assign hit_in_range = $signed({hit_ff[PHI_W-1], hit_ff}) < $signed({2'b00, phi_bins_ff});

   // shifted best distance and its range check
   assign idx_s  = IDX_W'(best_ff) + HALF_S;
   assign idx_ok = (idx_s >= 0) && (idx_s < PDF_SIZE_S);

   // wrap into about +-phi_bins/2
   assign phi_s  = DIST_W'({1'b0, phi_bins_ff});
   assign hb_s   = DIST_W'({1'b0, phi_bins_ff[PHI_BINS_W-1:1]});
   assign wrap_a = (best_ff >= hb_s) ? best_ff - phi_s : best_ff;
   assign wrap_b = (wrap_a <= -hb_s) ? wrap_a + phi_s : wrap_a;

   // saturating sum update
   assign sum_wide = (SUM_W+1)'(pair_rd_data.sum) + (SUM_W+1)'(wrap_ff);
   assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                     ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                     : sum_wide[SUM_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // state register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         phi_bins_ff   <= PHI_BINS_RESET;
         best_ff       <= BEST_INIT;
         valid_hits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         phi_bins_ff   <= phi_bins_in;
         best_ff       <= best_in;
         valid_hits_ff <= valid_hits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pair_ff     <= pair_in;
      ok_ff       <= ok_in;
      ref_ff      <= ref_in;
      hit_ff      <= hit_in;
      last_ff     <= last_in;
      bin_ff      <= bin_in;
      wval_ff     <= wval_in;
      sel_ok_ff   <= sel_ok_in;
      lut_addr_ff <= lut_addr_in;
      wrap_ff     <= wrap_in;
      rsp_pdf_ff  <= rsp_pdf_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // sequencer: next state, memory access and register updates
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      phi_bins_in   = csr_wr_en ? csr_wr_data : phi_bins_ff;
      best_in       = best_ff;
      valid_hits_in = valid_hits_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      cmd_in      = cmd_ff;
      pair_in     = pair_ff;
      ok_in       = ok_ff;
      ref_in      = ref_ff;
      hit_in      = hit_ff;
      last_in     = last_ff;
      bin_in      = bin_ff;
      wval_in     = wval_ff;
      sel_ok_in   = sel_ok_ff;
      lut_addr_in = lut_addr_ff;
      wrap_in     = wrap_ff;
      rsp_pdf_in  = rsp_pdf_ff;
      rsp_has_in  = rsp_has_ff;
      rsp_sum_in  = rsp_sum_ff;
      rsp_cnt_in  = rsp_cnt_ff;

      pdf_wr_en    = 1'b0;
      pdf_wr_addr  = PDF_AW'({pair_ff, bin_ff});
      pdf_wr_data  = wval_ff[PDF_W-1:0];
      pdf_rd_en    = 1'b0;
      pdf_rd_addr  = PDF_AW'({req_pair, req_bin});
      pair_wr_en   = 1'b0;
      pair_wr_addr = pair_ff;
      pair_wr_data = pair_rd_data;
      pair_rd_en   = 1'b0;
      pair_rd_addr = req_pair;

      unique case (state_ff)
         // zero both memories after reset
         ST_CLEAR: begin
            pdf_wr_en    = 1'b1;
            pdf_wr_addr  = clr_cnt_ff;
            pdf_wr_data  = '0;
            pair_wr_en   = (clr_cnt_ff < PAIRS_LIM);
            pair_wr_addr = clr_cnt_ff[PAIR_AW-1:0];
            pair_wr_data = '0;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == PDF_LAST) begin
               state_in = ST_IDLE;
            end
         end

         // take an item and start both reads
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in     = cmd_type'(req_command);
               pair_in    = req_pair;
               ok_in      = req_ok;
               ref_in     = req_ref_phi;
               hit_in     = req_hit_phi;
               last_in    = req_last_hit;
               bin_in     = req_bin;
               wval_in    = req_write_value;
               pdf_rd_en  = 1'b1;
               pair_rd_en = 1'b1;
               state_in   = ST_HIT;
            end
         end

         // pair word is available
         ST_HIT: begin
            state_in = ST_IDLE;
            unique case (cmd_ff)
               CMD_EVAL, CMD_ACCUM: begin
                  if (hit_in_range) begin
                     if (dist_mag(dist_s) < dist_mag(best_ff)) begin
                        best_in = dist_s;
                     end
                     if (valid_hits_ff != 2'd2) begin
                        valid_hits_in = valid_hits_ff + 2'd1;
                     end
                  end
                  if (last_ff) begin
                     state_in = ST_LAST;
                  end
               end
               CMD_WR_PDF: begin
                  pdf_wr_en = ok_ff;
               end
               CMD_WR_MEAN: begin
                  pair_wr_en        = ok_ff;
                  pair_wr_data.mean = wval_ff[PHI_W-1:0];
               end
               CMD_RD_STAT: begin
                  sel_ok_in = ok_ff;
                  state_in  = ST_OUT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // end of a hit list: look up the pdf bin of the best distance
         ST_LAST: begin
            lut_addr_in   = PDF_AW'({pair_ff, idx_s[PDF_ADDR_BITS-1:0]});
            pdf_rd_addr   = PDF_AW'({pair_ff, idx_s[PDF_ADDR_BITS-1:0]});
            if (cmd_ff == CMD_EVAL) begin
               best_in       = BEST_INIT;
               valid_hits_in = '0;
               sel_ok_in     = ok_ff && idx_ok;
               pdf_rd_en     = ok_ff && idx_ok;
               state_in      = ST_OUT;
            end else if (ok_ff && idx_ok && valid_hits_ff == 2'd1) begin
               // best distance is kept until the wrap state
               pdf_rd_en = 1'b1;
               state_in  = ST_WRAP;
            end else begin
               best_in       = BEST_INIT;
               valid_hits_in = '0;
               state_in      = ST_IDLE;
            end
         end

         // wrap the distance while the pdf bin is read
         ST_WRAP: begin
            wrap_in       = wrap_b;
            best_in       = BEST_INIT;
            valid_hits_in = '0;
            state_in      = ST_UPD;
         end

         // write back pdf bin, sum and count
         ST_UPD: begin
            pdf_wr_en          = 1'b1;
            pdf_wr_addr        = lut_addr_ff;
            pdf_wr_data        = (pdf_rd_data == PDF_MAX) ? pdf_rd_data
                                                          : pdf_rd_data + 1'b1;
            pair_wr_en         = 1'b1;
            pair_wr_data.sum   = sum_sat;
            pair_wr_data.count = (pair_rd_data.count == CNT_MAX) ? pair_rd_data.count
                                                                 : pair_rd_data.count + 1'b1;
            state_in           = ST_IDLE;
         end

         // load the response register once it is free
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pdf_in   = sel_ok_ff ? pdf_rd_data : '0;
               rsp_has_in   = sel_ok_ff && (pdf_rd_data != '0);
               if (cmd_ff == CMD_RD_STAT && sel_ok_ff) begin
                  rsp_sum_in = pair_rd_data.sum;
                  rsp_cnt_in = pair_rd_data.count;
               end else begin
                  rsp_sum_in = '0;
                  rsp_cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response outputs
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pdf_value  = rsp_pdf_ff;
   assign rsp_has_value  = rsp_has_ff;
   assign rsp_dist_sum   = rsp_sum_ff;
   assign rsp_dist_count = rsp_cnt_ff;

endmodule
